// ----- rtl/gdl_pkg.sv -----
package gdl_pkg;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 7;
  localparam int HOLE_W  = 11;
  localparam int SUM_W   = 22;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_HWALL   = 2'd0;
  localparam logic [OP_W-1:0] OP_VWALL   = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TANK = 2'd2;

endpackage

// ----- rtl/gdl_in_if.sv -----
interface gdl_in_if;
  logic                               valid;
  logic                               ready;
  logic [gdl_pkg::OP_W-1:0]           op;
  logic [gdl_pkg::IDX_W-1:0]          wall_row;
  logic [gdl_pkg::IDX_W-1:0]          wall_col;
  logic signed [gdl_pkg::HOLE_W-1:0]  hole_height;

  modport source (output valid, op, wall_row, wall_col, hole_height, input ready);
  modport sink   (input valid, op, wall_row, wall_col, hole_height, output ready);
endinterface

// ----- rtl/gdl_out_if.sv -----
interface gdl_out_if;
  logic                        valid;
  logic                        ready;
  logic [gdl_pkg::SUM_W-1:0]   remaining_water;

  modport source (output valid, remaining_water, input ready);
  modport sink   (input valid, remaining_water, output ready);
endinterface

// ----- rtl/gdl_ram.sv -----
module gdl_ram #(
  parameter int W  = 11,
  parameter int D  = 4160,
  parameter int AW = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr0,
  output logic [W-1:0]  rdata0,
  input  logic [AW-1:0] raddr1,
  output logic [W-1:0]  rdata1
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- rtl/grid_drain_level_solver_top.sv -----
// load items: one per cycle while idle (ready only in S_IDLE), no result
// compute: a fill pass reads the edge walls and writes each cell's level, then relaxation sweeps
// over each cell and its lower and right neighbours, repeated until a sweep changes no level,
// then a sum pass over every cell; the level memory has one write port and two read ports
// synchronous active-low reset clears control state and sets config to 1; hole stores undefined
module grid_drain_level_solver_top #(
  parameter int ROWS_MAX    = 64,
  parameter int COLS_MAX    = 64,
  parameter int HEIGHT_BITS = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gdl_in_if.sink                         in_s,
  gdl_out_if.source                      out_m,
  input  logic                           cfg_we,
  input  logic [gdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gdl_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int LW   = HEIGHT_BITS;
  localparam int HD   = (ROWS_MAX + 1) * COLS_MAX;
  localparam int VD   = ROWS_MAX * (COLS_MAX + 1);
  localparam int LD   = ROWS_MAX * COLS_MAX;
  localparam int HA   = (HD > 1) ? $clog2(HD) : 1;
  localparam int VA   = (VD > 1) ? $clog2(VD) : 1;
  localparam int LA   = (LD > 1) ? $clog2(LD) : 1;
  localparam int RCW  = $clog2(ROWS_MAX + 1);
  localparam int CCW  = $clog2(COLS_MAX + 1);
  localparam int HW   = gdl_pkg::HOLE_W;
  localparam int CW   = 17;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FILL_RD = 4'd1;
  localparam logic [3:0] S_FILL_WR = 4'd2;
  localparam logic [3:0] S_PAIR_RD = 4'd3;
  localparam logic [3:0] S_PAIR_WA = 4'd4;
  localparam logic [3:0] S_PAIR_WB = 4'd5;
  localparam logic [3:0] S_SUM_RD  = 4'd6;
  localparam logic [3:0] S_SUM_ACC = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]                  state_r, state_nxt;
  logic [6:0]                  row_cfg_r, col_cfg_r;
  logic [gdl_pkg::CFG_W-1:0]   tank_r;
  logic [RCW-1:0]              rows_r, rows_nxt, r_r, r_nxt;
  logic [CCW-1:0]              cols_r, cols_nxt, c_r, c_nxt;
  logic                        dir_r, dir_nxt, changed_r, changed_nxt;
  logic [gdl_pkg::SUM_W-1:0]   sum_r, sum_nxt, out_data_r, out_data_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic          h_we, v_we, l_we;
  logic [HA-1:0] h_waddr, h_ra0, h_ra1;
  logic [VA-1:0] v_waddr, v_ra0, v_ra1;
  logic [LA-1:0] l_waddr, l_ra0, l_ra1;
  logic [HW-1:0] h_rd0, h_rd1, v_rd0, v_rd1;
  logic [LW-1:0] l_wdata, l_rd0, l_rd1;
  logic [LW-1:0] fill_lvl, na, nb;
  logic          pair_ok, last_cell, in_acc;
  logic [HW-1:0] pair_hole;

  function automatic logic [LW-1:0] clip(input logic [LW-1:0] lvl, input logic [HW-1:0] h);
    logic [LW-1:0] res;
    res = lvl;
    if (!h[HW-1] && (CW'(h[HW-2:0]) < CW'(lvl))) begin
      res = LW'(h[HW-2:0]);
    end
    return res;
  endfunction

  function automatic logic [LW-1:0] relax_f(input logic [LW-1:0] a, input logic [LW-1:0] b,
                                            input logic [HW-1:0] h);
    logic [LW-1:0] m, res;
    m = clip(b, h);
    if (a > m) begin
      m = a;
    end
    res = b;
    if (!h[HW-1] && (m < b)) begin
      res = m;
    end
    return res;
  endfunction

  gdl_ram #(.W(HW), .D(HD), .AW(HA)) u_hmem (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(in_s.hole_height),
    .raddr0(h_ra0), .rdata0(h_rd0), .raddr1(h_ra1), .rdata1(h_rd1)
  );

  gdl_ram #(.W(HW), .D(VD), .AW(VA)) u_vmem (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(in_s.hole_height),
    .raddr0(v_ra0), .rdata0(v_rd0), .raddr1(v_ra1), .rdata1(v_rd1)
  );

  gdl_ram #(.W(LW), .D(LD), .AW(LA)) u_lmem (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr0(l_ra0), .rdata0(l_rd0), .raddr1(l_ra1), .rdata1(l_rd1)
  );

  assign in_s.ready            = (state_r == S_IDLE);
  assign in_acc                = in_s.valid && in_s.ready;
  assign out_m.valid           = out_valid_r;
  assign out_m.remaining_water = out_data_r;

  // wall loads
  always_comb begin
    h_we    = in_acc && (in_s.op == gdl_pkg::OP_HWALL) &&
              (int'(in_s.wall_row) <= ROWS_MAX) && (int'(in_s.wall_col) < COLS_MAX);
    v_we    = in_acc && (in_s.op == gdl_pkg::OP_VWALL) &&
              (int'(in_s.wall_row) < ROWS_MAX) && (int'(in_s.wall_col) <= COLS_MAX);
    h_waddr = HA'(int'(in_s.wall_row) * COLS_MAX + int'(in_s.wall_col));
    v_waddr = VA'(int'(in_s.wall_row) * (COLS_MAX + 1) + int'(in_s.wall_col));
  end

  // read addresses
  always_comb begin
    if (state_r == S_FILL_RD || state_r == S_FILL_WR) begin
      h_ra0 = HA'(int'(c_r));
      v_ra0 = VA'(int'(r_r) * (COLS_MAX + 1));
    end else begin
      h_ra0 = HA'((int'(r_r) + 1) * COLS_MAX + int'(c_r));
      v_ra0 = VA'(int'(r_r) * (COLS_MAX + 1) + int'(c_r) + 1);
    end
    h_ra1 = HA'(int'(rows_r) * COLS_MAX + int'(c_r));
    v_ra1 = VA'(int'(r_r) * (COLS_MAX + 1) + int'(cols_r));
    l_ra0 = LA'(int'(r_r) * COLS_MAX + int'(c_r));
    l_ra1 = dir_r ? LA'(int'(r_r) * COLS_MAX + int'(c_r) + 1)
                  : LA'((int'(r_r) + 1) * COLS_MAX + int'(c_r));
  end

  always_comb begin
    fill_lvl = LW'(tank_r);
    if (r_r == '0) begin
      fill_lvl = clip(fill_lvl, h_rd0);
    end
    if (int'(r_r) + 1 == int'(rows_r)) begin
      fill_lvl = clip(fill_lvl, h_rd1);
    end
    if (c_r == '0) begin
      fill_lvl = clip(fill_lvl, v_rd0);
    end
    if (int'(c_r) + 1 == int'(cols_r)) begin
      fill_lvl = clip(fill_lvl, v_rd1);
    end
    pair_hole = dir_r ? v_rd0 : h_rd0;
    na        = relax_f(l_rd1, l_rd0, pair_hole);
    nb        = relax_f(l_rd0, l_rd1, pair_hole);
    pair_ok   = dir_r ? (int'(c_r) + 1 < int'(cols_r)) : (int'(r_r) + 1 < int'(rows_r));
    last_cell = (int'(r_r) + 1 == int'(rows_r)) && (int'(c_r) + 1 == int'(cols_r));
  end

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    dir_nxt       = dir_r;
    changed_nxt   = changed_r;
    sum_nxt       = sum_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_m.ready;
    l_we          = 1'b0;
    l_waddr       = l_ra0;
    l_wdata       = fill_lvl;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_s.op == gdl_pkg::OP_COMPUTE) begin
          rows_nxt  = (row_cfg_r == '0) ? RCW'(1) :
                      (int'(row_cfg_r) > ROWS_MAX) ? RCW'(ROWS_MAX) : RCW'(row_cfg_r);
          cols_nxt  = (col_cfg_r == '0) ? CCW'(1) :
                      (int'(col_cfg_r) > COLS_MAX) ? CCW'(COLS_MAX) : CCW'(col_cfg_r);
          r_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_FILL_RD;
        end
      end
      S_FILL_RD: state_nxt = S_FILL_WR;
      S_FILL_WR: begin
        l_we = 1'b1;
        if (last_cell) begin
          r_nxt       = '0;
          c_nxt       = '0;
          dir_nxt     = 1'b0;
          changed_nxt = 1'b0;
          state_nxt   = S_PAIR_RD;
        end else begin
          state_nxt = S_FILL_RD;
          if (int'(c_r) + 1 == int'(cols_r)) begin
            c_nxt = '0;
            r_nxt = r_r + RCW'(1);
          end else begin
            c_nxt = c_r + CCW'(1);
          end
        end
      end
      S_PAIR_RD, S_PAIR_WB: begin
        if (state_r == S_PAIR_WB) begin
          l_we    = 1'b1;
          l_waddr = l_ra1;
          l_wdata = nb;
          if (nb != l_rd1) begin
            changed_nxt = 1'b1;
          end
        end
        if (state_r == S_PAIR_RD && pair_ok) begin
          state_nxt = S_PAIR_WA;
        end else if (!dir_r) begin
          dir_nxt   = 1'b1;
          state_nxt = S_PAIR_RD;
        end else begin
          dir_nxt   = 1'b0;
          state_nxt = S_PAIR_RD;
          if (last_cell) begin
            r_nxt = '0;
            c_nxt = '0;
            if (changed_nxt) begin
              changed_nxt = 1'b0;
            end else begin
              sum_nxt   = '0;
              state_nxt = S_SUM_RD;
            end
          end else if (int'(c_r) + 1 == int'(cols_r)) begin
            c_nxt = '0;
            r_nxt = r_r + RCW'(1);
          end else begin
            c_nxt = c_r + CCW'(1);
          end
        end
      end
      S_PAIR_WA: begin
        l_we    = 1'b1;
        l_wdata = na;
        if (na != l_rd0) begin
          changed_nxt = 1'b1;
        end
        state_nxt = S_PAIR_WB;
      end
      S_SUM_RD: state_nxt = S_SUM_ACC;
      S_SUM_ACC: begin
        sum_nxt = sum_r + gdl_pkg::SUM_W'(l_rd0);
        if (last_cell) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SUM_RD;
          if (int'(c_r) + 1 == int'(cols_r)) begin
            c_nxt = '0;
            r_nxt = r_r + RCW'(1);
          end else begin
            c_nxt = c_r + CCW'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_nxt) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sum_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_cfg_r   <= 7'd1;
      col_cfg_r   <= 7'd1;
      tank_r      <= gdl_pkg::CFG_W'(1);
      changed_r   <= 1'b0;
      dir_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      changed_r   <= changed_nxt;
      dir_r       <= dir_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          gdl_pkg::CFG_ROWS: row_cfg_r <= cfg_wdata[6:0];
          gdl_pkg::CFG_COLS: col_cfg_r <= cfg_wdata[6:0];
          gdl_pkg::CFG_TANK: tank_r    <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rows_r     <= rows_nxt;
    cols_r     <= cols_nxt;
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    sum_r      <= sum_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int RMAX = 64;
  localparam int CMAX = 64;
  localparam int WDOG_LIMIT = 600000;
  localparam int ITEM_TARGET = 1350;
  localparam logic [gdl_pkg::OP_W-1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [gdl_pkg::OP_W-1:0]   op;
    logic [gdl_pkg::IDX_W-1:0]  wr;
    logic [gdl_pkg::IDX_W-1:0]  wc;
    logic [gdl_pkg::HOLE_W-1:0] hole;
  } wall_req_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [gdl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [gdl_pkg::CFG_W-1:0] cfg_wdata;

  gdl_in_if in_if();
  gdl_out_if out_if();

  grid_drain_level_solver_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_s(in_if),
    .out_m(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  wall_req_t req_q[$];
  logic [gdl_pkg::SUM_W-1:0] water_q[$];
  int req_total;
  int acc_count;
  int result_count;
  int err_cnt;
  int wdog;
  int hold_left;
  bit hold_req;
  bit in_acc;

  int m_rows, m_cols, m_tank;
  int h_hole[RMAX+1][CMAX];
  int v_hole[RMAX][CMAX+1];

  function automatic int send_idle_pct();
    if (acc_count < 450) return 35;
    if (acc_count < 900) return 52;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (acc_count < 450) return 52;
    if (acc_count < 900) return 35;
    return 0;
  endfunction

  function automatic int sat_dim(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [gdl_pkg::SUM_W-1:0] predict_water();
    int rows, cols, lv[RMAX][CMAX], nh, h, sum;
    bit changed;
    rows = sat_dim(m_rows, RMAX);
    cols = sat_dim(m_cols, CMAX);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++) lv[r][c] = m_tank;
    for (int c = 0; c < cols; c++) begin
      h = h_hole[0][c];
      if (h >= 0 && lv[0][c] > h) lv[0][c] = h;
      h = h_hole[rows][c];
      if (h >= 0 && lv[rows-1][c] > h) lv[rows-1][c] = h;
    end
    for (int r = 0; r < rows; r++) begin
      h = v_hole[r][0];
      if (h >= 0 && lv[r][0] > h) lv[r][0] = h;
      h = v_hole[r][cols];
      if (h >= 0 && lv[r][cols-1] > h) lv[r][cols-1] = h;
    end
    // relax to the fixed point: each level is the lowest bottleneck to the outside
    changed = 1;
    while (changed) begin
      changed = 0;
      for (int r = 0; r < rows; r++)
        for (int c = 0; c < cols; c++) begin
          for (int d = 0; d < 4; d++) begin
            int nr, nc;
            nr = r; nc = c;
            case (d)
              0: begin nr = r - 1; h = (r > 0) ? h_hole[r][c] : -1; end
              1: begin nr = r + 1; h = (r + 1 < rows) ? h_hole[r+1][c] : -1; end
              2: begin nc = c - 1; h = (c > 0) ? v_hole[r][c] : -1; end
              default: begin nc = c + 1; h = (c + 1 < cols) ? v_hole[r][c+1] : -1; end
            endcase
            if (h >= 0) begin
              nh = (h < lv[nr][nc]) ? h : lv[nr][nc];
              if (lv[r][c] > nh) nh = lv[r][c];
              if (lv[nr][nc] > nh) begin
                lv[nr][nc] = nh;
                changed = 1;
              end
            end
          end
        end
    end
    sum = 0;
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++) sum += lv[r][c];
    return sum[gdl_pkg::SUM_W-1:0];
  endfunction

  function automatic void apply_request(wall_req_t q);
    int hole;
    hole = $signed(q.hole);
    if (hole < 0) hole = -1;
    case (q.op)
      gdl_pkg::OP_HWALL: if (q.wr <= RMAX && q.wc < CMAX) h_hole[q.wr][q.wc] = hole;
      gdl_pkg::OP_VWALL: if (q.wr < RMAX && q.wc <= CMAX) v_hole[q.wr][q.wc] = hole;
      gdl_pkg::OP_COMPUTE: water_q.push_back(predict_water());
      default: ;
    endcase
  endfunction

  // clock, reset and known input levels
  initial begin
    clk = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = gdl_pkg::CFG_ROWS;
    cfg_wdata = '0;
    in_if.valid = 0;
    in_if.op = gdl_pkg::OP_HWALL;
    in_if.wall_row = '0;
    in_if.wall_col = '0;
    in_if.hole_height = '0;
    out_if.ready = 0;
    forever #6 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 0;
    end else if (!in_if.valid || in_acc) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
        wall_req_t q;
        q = req_q.pop_front();
        in_if.op <= q.op;
        in_if.wall_row <= q.wr;
        in_if.wall_col <= q.wc;
        in_if.hole_height <= q.hole;
        in_if.valid <= 1;
      end else begin
        in_if.valid <= 0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
      out_if.ready <= 0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // monitors and watchdog
  always @(posedge clk) begin
    in_acc <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        wdog <= 0;
      end else begin
        wdog <= wdog + 1;
      end
      if (in_if.valid && in_if.ready) begin
        wall_req_t q;
        q.op = in_if.op;
        q.wr = in_if.wall_row;
        q.wc = in_if.wall_col;
        q.hole = in_if.hole_height;
        apply_request(q);
        acc_count <= acc_count + 1;
      end
      if (out_if.valid && out_if.ready) begin
        result_count <= result_count + 1;
        if (water_q.size() == 0) begin
          $error("remaining_water: unexpected result %0d", out_if.remaining_water);
          err_cnt++;
        end else begin
          logic [gdl_pkg::SUM_W-1:0] exp_w;
          exp_w = water_q.pop_front();
          if (out_if.remaining_water !== exp_w) begin
            $error("remaining_water: expected %0d actual %0d", exp_w, out_if.remaining_water);
            err_cnt++;
          end
        end
      end
      if (wdog >= WDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push_req(logic [gdl_pkg::OP_W-1:0] op, int wr, int wc,
                          logic [gdl_pkg::HOLE_W-1:0] hole);
    wall_req_t q;
    q.op = op;
    q.wr = wr[gdl_pkg::IDX_W-1:0];
    q.wc = wc[gdl_pkg::IDX_W-1:0];
    q.hole = hole;
    req_q.push_back(q);
    req_total++;
  endtask

  function automatic logic [gdl_pkg::HOLE_W-1:0] rand_hole();
    case ($urandom_range(9))
      0, 1: return '1;
      2: return gdl_pkg::HOLE_W'(11'h400 | $urandom_range(1023));
      3, 4, 5: return gdl_pkg::HOLE_W'($urandom_range(m_tank));
      default: return gdl_pkg::HOLE_W'($urandom_range(1023));
    endcase
  endfunction

  task automatic push_wall_in_grid(int rows, int cols);
    if ($urandom_range(1))
      push_req(gdl_pkg::OP_HWALL, $urandom_range(rows), $urandom_range(cols - 1), rand_hole());
    else
      push_req(gdl_pkg::OP_VWALL, $urandom_range(rows - 1), $urandom_range(cols), rand_hole());
  endtask

  task automatic load_all_walls(int rows, int cols);
    for (int r = 0; r <= rows; r++)
      for (int c = 0; c < cols; c++) push_req(gdl_pkg::OP_HWALL, r, c, rand_hole());
    for (int r = 0; r < rows; r++)
      for (int c = 0; c <= cols; c++) push_req(gdl_pkg::OP_VWALL, r, c, rand_hole());
  endtask

  task automatic push_noise();
    case ($urandom_range(2))
      0: push_req(OP_NONE, $urandom_range(127), $urandom_range(127),
                  gdl_pkg::HOLE_W'($urandom));
      1: push_req(gdl_pkg::OP_HWALL, $urandom_range(127), $urandom_range(127, CMAX),
                  gdl_pkg::HOLE_W'($urandom));
      default: push_req(gdl_pkg::OP_VWALL, $urandom_range(127, RMAX), $urandom_range(127),
                        gdl_pkg::HOLE_W'($urandom));
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (req_q.size() > 0 || in_if.valid || water_q.size() > 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [gdl_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val[gdl_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      gdl_pkg::CFG_ROWS: m_rows = val & 8'h7f;
      gdl_pkg::CFG_COLS: m_cols = val & 8'h7f;
      default: m_tank = val & 10'h3ff;
    endcase
  endtask

  task automatic run_grid(int rows, int cols, int tank, int mixed, bit burst);
    int er, ec;
    write_cfg(gdl_pkg::CFG_ROWS, rows);
    write_cfg(gdl_pkg::CFG_COLS, cols);
    write_cfg(gdl_pkg::CFG_TANK, tank);
    er = sat_dim(m_rows, RMAX);
    ec = sat_dim(m_cols, CMAX);
    load_all_walls(er, ec);
    push_req(gdl_pkg::OP_COMPUTE, 0, 0, '0);
    if (burst) begin
      hold_req = 1;
      for (int i = 0; i < 12; i++) push_req(gdl_pkg::OP_COMPUTE, 0, 0, '0);
    end
    for (int i = 0; i < mixed; i++) begin
      case ($urandom_range(9))
        0, 1: push_req(gdl_pkg::OP_COMPUTE, 0, 0, '0);
        2: push_noise();
        default: push_wall_in_grid(er, ec);
      endcase
    end
    push_req(gdl_pkg::OP_COMPUTE, 0, 0, '0);
    wait_idle();
  endtask

  initial begin
    req_total = 0;
    acc_count = 0;
    result_count = 0;
    err_cnt = 0;
    wdog = 0;
    hold_req = 0;
    m_rows = 1;
    m_cols = 1;
    m_tank = 1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // single cell at reset settings
    push_req(gdl_pkg::OP_HWALL, 0, 0, '1);
    push_req(gdl_pkg::OP_HWALL, 1, 0, '1);
    push_req(gdl_pkg::OP_VWALL, 0, 0, '1);
    push_req(gdl_pkg::OP_VWALL, 0, 1, '1);
    push_req(gdl_pkg::OP_COMPUTE, 0, 0, '0);
    push_req(gdl_pkg::OP_VWALL, 0, 1, 11'd0);
    push_req(gdl_pkg::OP_COMPUTE, 0, 0, '0);
    push_req(gdl_pkg::OP_VWALL, 0, 1, 11'h400);
    push_req(OP_NONE, 127, 127, 11'h7ff);
    push_req(gdl_pkg::OP_HWALL, 0, 64, 11'd0);
    push_req(gdl_pkg::OP_HWALL, 127, 0, 11'd0);
    push_req(gdl_pkg::OP_VWALL, 64, 0, 11'd0);
    push_req(gdl_pkg::OP_VWALL, 0, 127, 11'd0);
    push_req(gdl_pkg::OP_COMPUTE, 0, 0, '0);
    push_req(gdl_pkg::OP_HWALL, 1, 0, 11'd1022);
    push_req(gdl_pkg::OP_COMPUTE, 0, 0, '0);
    push_req(gdl_pkg::OP_HWALL, 0, 0, 11'd1023);
    push_req(gdl_pkg::OP_COMPUTE, 0, 0, '0);
    push_req(gdl_pkg::OP_HWALL, 0, 0, 11'd0);
    push_req(gdl_pkg::OP_COMPUTE, 0, 0, '0);
    wait_idle();

    // saturated and extreme settings
    run_grid(127, 1, 1023, 20, 0);
    run_grid(1, 127, 0, 20, 0);
    run_grid(0, 0, 1023, 10, 0);
    run_grid(64, 2, 700, 20, 0);
    run_grid(3, 3, 9, 10, 1);

    while (req_total < ITEM_TARGET || result_count < 60) begin
      run_grid($urandom_range(1, 10), $urandom_range(1, 10), $urandom_range(1023),
               $urandom_range(20, 60), 0);
    end
    wait_idle();

    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
